// ===== rtl/svo_pkg.sv =====
// ----------------------------------------------------------------------------
// svo_pkg - shared constants for the second-order servo model
// Sizes, register indexes, fixed-point coefficients and the angle clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package svo_pkg;

   localparam int DELAY_DEPTH  = 512;
   localparam int MAX_SUBSTEPS = 255;
   localparam int RING_AW      = $clog2(DELAY_DEPTH);
   localparam int SUB_W        = $clog2(MAX_SUBSTEPS + 1);

   // setup register indexes; the last code names no register
   typedef enum logic [2:0] {
      CSR_PWM_LO  = 3'd0,
      CSR_PWM_HI  = 3'd1,
      CSR_ANG_LO  = 3'd2,
      CSR_SLOPE   = 3'd3,
      CSR_DELAY   = 3'd4,
      CSR_NSUB    = 3'd5,
      CSR_SUBLEN  = 3'd6,
      CSR_SPARE   = 3'd7
   } csr_idx_type;

   // Q.16 coefficients of the response and the slew law
   localparam logic signed [28:0] WN2_Q16       = 29'sd144153641;
   localparam logic signed [23:0] DAMP_Q16      = 24'sd4647341;
   localparam logic signed [16:0] GAIN_Q16      = 17'sd62915;
   localparam logic        [18:0] SLEW_NOLOAD   = 19'd411775;
   localparam logic        [18:0] SLEW_FULLLOAD = 19'd68629;
   localparam logic        [18:0] SLEW_SPAN     = 19'd343146;

   localparam logic signed [39:0] ANG_MAX = 40'sd524287;
   localparam logic signed [39:0] ANG_MIN = -40'sd524288;

   function automatic logic signed [19:0] sat20(input logic signed [39:0] v);
      logic signed [19:0] r;
      if (v > ANG_MAX) begin
         r = 20'sh7FFFF;
      end else if (v < ANG_MIN) begin
         r = 20'sh80000;
      end else begin
         r = v[19:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/svo_ram.sv =====
// ----------------------------------------------------------------------------
// svo_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module svo_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/servo_second_order_model.sv =====
// ----------------------------------------------------------------------------
// servo_second_order_model - one servo channel, one frame per word
// Pulse clamp and mapping, transport delay ring, damped second-order response.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ carries one frame word (pulse width, load scale); it is taken when
//    req_valid is high and req_stall is low. req_stall is high while a frame
//    is being worked on.
//  - rsp_ returns one word per frame: angle, rate, command, slew limit. It is
//    held in an output register until taken (rsp_valid high, rsp_stall low).
//  - csr_ writes the seven setup registers; write only while idle.
//  - Timing: a frame runs the command, seed, prepare, target and slew steps,
//    then N substeps, N the clamped substep count. Each substep is the
//    six-step sequence (two products, accumulate, two Euler multiplies with
//    their updates) that shares the state registers.
//  - The delay ring lives in a one-port-write, one-port-read RAM; the write
//    of the new command and the read of the delayed one share one cycle.
//  - Reset clears the setup registers to defaults and marks the model
//    unseeded. The first frame seeds angle and ring with its command; ring
//    entries not yet written since seeding read as that seed value, so no
//    clearing pass is needed.
//  - A stalled rsp_ word holds; a finished frame waits in its last step until
//    the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_second_order_model (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [23:0]        csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [11:0]        req_pwm_in,
   input  wire logic [23:0]        req_load_scale,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [19:0]      rsp_actual_angle,
   output logic signed [19:0]      rsp_angular_velocity,
   output logic signed [19:0]      rsp_commanded_angle,
   output logic        [18:0]      rsp_slew_limit
);

   localparam int AW  = svo_pkg::RING_AW;
   localparam int SW  = svo_pkg::SUB_W;
   localparam int NDW = (AW > 9) ? AW : 9;
   localparam int NSW = (SW > 8) ? SW : 8;

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_CMD  = 13'b0000000000010,
      S_SEED = 13'b0000000000100,
      S_PREP = 13'b0000000001000,
      S_TGT  = 13'b0000000010000,
      S_SLEW = 13'b0000000100000,
      S_MUL  = 13'b0000001000000,
      S_ACC  = 13'b0000010000000,
      S_HMUL = 13'b0000100000000,
      S_RATE = 13'b0001000000000,
      S_RMUL = 13'b0010000000000,
      S_ANG  = 13'b0100000000000,
      S_DONE = 13'b1000000000000
   } state_type;

   // setup registers
   logic        [11:0] pwm_lo_ff, pwm_hi_ff;
   logic signed [19:0] ang_lo_ff;
   logic signed [23:0] slope_ff;
   logic        [8:0]  dly_ff;
   logic        [7:0]  nsub_cfg_ff;
   logic        [23:0] hlen_ff;

   state_type state_ff;

   logic        [11:0] pwm_ff;
   logic        [23:0] load_ff;
   logic signed [36:0] cmd_prod_ff;
   logic signed [19:0] cmd_ff, seed_val_ff;
   logic               seeded_ff;
   logic        [AW-1:0] head_ff, fill_ff;
   logic               fwd_ff, ring_hit_ff;
   logic signed [19:0] angle_ff, rate_ff;
   logic        [43:0] ratio_prod_ff;
   logic               ratio_big_ff;
   logic        [34:0] span_prod_ff;
   logic        [18:0] slew_ff;
   logic signed [20:0] target_ff;
   logic signed [50:0] p_wn_ff;
   logic signed [43:0] p_dp_ff;
   logic signed [33:0] acc_ff;
   logic signed [58:0] p_h_ff;
   logic signed [44:0] p_r_ff;
   logic        [SW-1:0] sub_ff;
   logic               rsp_valid_ff;
   logic signed [19:0] rsp_angle_ff, rsp_rate_ff, rsp_cmd_ff;
   logic        [18:0] rsp_slew_ff;

   // ---------------- setup port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_lo_ff   <= 12'd1000;
         pwm_hi_ff   <= 12'd2000;
         ang_lo_ff   <= -20'sd32768;
         slope_ff    <= 24'sd1092;
         dly_ff      <= 9'd14;
         nsub_cfg_ff <= 8'd1;
         hlen_ff     <= 24'd16777;
      end else if (csr_wr_en) begin
         case (csr_index)
            svo_pkg::CSR_PWM_LO: pwm_lo_ff   <= csr_wr_data[11:0];
            svo_pkg::CSR_PWM_HI: pwm_hi_ff   <= csr_wr_data[11:0];
            svo_pkg::CSR_ANG_LO: ang_lo_ff   <= csr_wr_data[19:0];
            svo_pkg::CSR_SLOPE:  slope_ff    <= csr_wr_data;
            svo_pkg::CSR_DELAY:  dly_ff      <= csr_wr_data[8:0];
            svo_pkg::CSR_NSUB:   nsub_cfg_ff <= csr_wr_data[7:0];
            svo_pkg::CSR_SUBLEN: hlen_ff     <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // ---------------- derived setup values ----------------
   logic [NDW-1:0] dly_ext, dly_sat;
   logic [AW-1:0]  nd;
   logic [NSW-1:0] nsub_ext, nsub_sat;
   logic [SW-1:0]  nsub;

   always_comb begin
      dly_ext = NDW'(dly_ff);
      dly_sat = (dly_ext > NDW'(svo_pkg::DELAY_DEPTH - 1)) ?
                NDW'(svo_pkg::DELAY_DEPTH - 1) : dly_ext;
      nd      = dly_sat[AW-1:0];
      nsub_ext = NSW'(nsub_cfg_ff);
      if (nsub_ext == '0) begin
         nsub_sat = NSW'(1);
      end else if (nsub_ext > NSW'(svo_pkg::MAX_SUBSTEPS)) begin
         nsub_sat = NSW'(svo_pkg::MAX_SUBSTEPS);
      end else begin
         nsub_sat = nsub_ext;
      end
      nsub = nsub_sat[SW-1:0];
   end

   // ---------------- command mapping ----------------
   logic [11:0]        pulse_hi, pulse;
   logic [11:0]        pulse_off;
   logic signed [36:0] cmd_prod;
   logic signed [36:0] cmd_rnd;
   logic signed [19:0] cmd_val;

   always_comb begin
      pulse_hi  = (pwm_ff > pwm_hi_ff) ? pwm_hi_ff : pwm_ff;
      pulse     = (pulse_hi < pwm_lo_ff) ? pwm_lo_ff : pulse_hi;
      pulse_off = pulse - pwm_lo_ff;
      cmd_prod  = slope_ff * $signed({1'b0, pulse_off});
      cmd_rnd   = (cmd_prod_ff + 37'sd128) >>> 8;
      cmd_val   = svo_pkg::sat20(40'(ang_lo_ff) + 40'(cmd_rnd));
   end

   // ---------------- delay ring ----------------
   logic [AW-1:0] head_nx, rd_idx, fill_nx;
   logic [AW:0]   head_sum;
   logic [19:0]   ring_rd;
   logic          ring_we;

   always_comb begin
      head_nx  = (head_ff == AW'(svo_pkg::DELAY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      if (head_nx >= nd) begin
         head_sum = {1'b0, head_nx} - {1'b0, nd};
      end else begin
         head_sum = {1'b0, head_nx} + (AW + 1)'(svo_pkg::DELAY_DEPTH) - {1'b0, nd};
      end
      rd_idx   = head_sum[AW-1:0];
      fill_nx  = (fill_ff == AW'(svo_pkg::DELAY_DEPTH - 1)) ? fill_ff : fill_ff + 1'b1;
      ring_we  = (state_ff == S_PREP);
   end

   svo_ram #(
      .WIDTH (20),
      .DEPTH (svo_pkg::DELAY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (head_nx),
      .wr_data (cmd_ff),
      .rd_addr (rd_idx),
      .rd_data (ring_rd)
   );

   // ---------------- slew law and target ----------------
   logic signed [20:0] angle_neg;
   logic        [19:0] angle_abs;
   logic        [44:0] ratio_sum;
   logic        [28:0] ratio;
   logic signed [19:0] u_val;
   logic signed [36:0] tgt_prod;
   logic signed [36:0] tgt_rnd;
   logic        [35:0] span_sum;
   logic        [19:0] span_rnd;
   logic signed [20:0] slew_raw;
   logic        [18:0] slew_val;

   always_comb begin
      angle_neg = -21'(angle_ff);
      angle_abs = angle_ff[19] ? angle_neg[19:0] : angle_ff;
      ratio_sum = 45'(ratio_prod_ff) + 45'd32768;
      ratio     = ratio_sum[44:16];
      if (fwd_ff) begin
         u_val = cmd_ff;
      end else if (ring_hit_ff) begin
         u_val = ring_rd;
      end else begin
         u_val = seed_val_ff;
      end
      tgt_prod = svo_pkg::GAIN_Q16 * u_val;
      tgt_rnd  = (tgt_prod + 37'sd32768) >>> 16;
      span_sum = 36'(span_prod_ff) + 36'd32768;
      span_rnd = span_sum[35:16];
      slew_raw = $signed({2'b00, svo_pkg::SLEW_NOLOAD}) - $signed({1'b0, span_rnd});
      if (ratio_big_ff) begin
         slew_val = svo_pkg::SLEW_FULLLOAD;
      end else if (slew_raw > $signed({2'b00, svo_pkg::SLEW_NOLOAD})) begin
         slew_val = svo_pkg::SLEW_NOLOAD;
      end else if (slew_raw < $signed({2'b00, svo_pkg::SLEW_FULLLOAD})) begin
         slew_val = svo_pkg::SLEW_FULLLOAD;
      end else begin
         slew_val = slew_raw[18:0];
      end
   end

   // ---------------- substep datapath ----------------
   logic signed [21:0] ang_err;
   logic signed [51:0] acc_sum;
   logic signed [24:0] h_s;
   logic signed [59:0] rinc_sum;
   logic signed [36:0] rate_sum, slew_pos;
   logic signed [19:0] rate_new;
   logic signed [45:0] ainc_sum;
   logic signed [19:0] angle_new;

   always_comb begin
      ang_err  = 22'(target_ff) - 22'(angle_ff);
      acc_sum  = 52'(p_wn_ff) - 52'(p_dp_ff) + 52'sd32768;
      h_s      = $signed({1'b0, hlen_ff});
      rinc_sum = 60'(p_h_ff) + 60'sd8388608;
      rate_sum = 37'(rate_ff) + 37'($signed(rinc_sum[59:24]));
      slew_pos = $signed({18'b0, slew_ff});
      if (rate_sum > slew_pos) begin
         rate_new = slew_pos[19:0];
      end else if (rate_sum < -slew_pos) begin
         rate_new = 20'(-slew_pos);
      end else begin
         rate_new = rate_sum[19:0];
      end
      ainc_sum  = 46'(p_r_ff) + 46'sd8388608;
      angle_new = svo_pkg::sat20(40'(angle_ff) + 40'($signed(ainc_sum[45:24])));
   end

   // ---------------- sequencer ----------------
   logic req_take, rsp_load;

   assign req_take = req_valid && (state_ff == S_IDLE);
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         seeded_ff <= 1'b0;
         angle_ff  <= '0;
         rate_ff   <= '0;
         head_ff   <= '0;
         fill_ff   <= '0;
         sub_ff    <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  state_ff <= S_CMD;
               end
            end
            S_CMD: state_ff <= S_SEED;
            S_SEED: begin
               if (!seeded_ff) begin
                  seeded_ff <= 1'b1;
                  angle_ff  <= cmd_val;
                  rate_ff   <= '0;
                  head_ff   <= '0;
                  fill_ff   <= '0;
               end
               state_ff <= S_PREP;
            end
            S_PREP: begin
               // advance the head, write the new command, read the delayed one
               head_ff  <= head_nx;
               fill_ff  <= fill_nx;
               state_ff <= S_TGT;
            end
            S_TGT:  state_ff <= S_SLEW;
            S_SLEW: begin
               sub_ff   <= '0;
               state_ff <= S_MUL;
            end
            S_MUL:  state_ff <= S_ACC;
            S_ACC:  state_ff <= S_HMUL;
            S_HMUL: state_ff <= S_RATE;
            S_RATE: begin
               rate_ff  <= rate_new;
               state_ff <= S_RMUL;
            end
            S_RMUL: state_ff <= S_ANG;
            S_ANG: begin
               angle_ff <= angle_new;
               sub_ff   <= sub_ff + 1'b1;
               state_ff <= (sub_ff == nsub - 1'b1) ? S_DONE : S_MUL;
            end
            S_DONE: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // payload and product registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         pwm_ff  <= req_pwm_in;
         load_ff <= req_load_scale;
      end
      if (state_ff == S_CMD) begin
         cmd_prod_ff <= cmd_prod;
      end
      if (state_ff == S_SEED) begin
         cmd_ff <= cmd_val;
         if (!seeded_ff) begin
            seed_val_ff <= cmd_val;
         end
      end
      if (state_ff == S_PREP) begin
         ratio_prod_ff <= load_ff * angle_abs;
         fwd_ff        <= (nd == '0);
         ring_hit_ff   <= (nd <= fill_ff);
      end
      if (state_ff == S_TGT) begin
         target_ff    <= tgt_rnd[20:0];
         ratio_big_ff <= (ratio[28:16] != '0);
         span_prod_ff <= svo_pkg::SLEW_SPAN * ratio[15:0];
      end
      if (state_ff == S_SLEW) begin
         slew_ff <= slew_val;
      end
      if (state_ff == S_MUL) begin
         p_wn_ff <= svo_pkg::WN2_Q16 * ang_err;
         p_dp_ff <= svo_pkg::DAMP_Q16 * rate_ff;
      end
      if (state_ff == S_ACC) begin
         acc_ff <= acc_sum[49:16];
      end
      if (state_ff == S_HMUL) begin
         p_h_ff <= acc_ff * h_s;
      end
      if (state_ff == S_RMUL) begin
         p_r_ff <= rate_ff * h_s;
      end
      if (rsp_load) begin
         rsp_angle_ff <= angle_ff;
         rsp_rate_ff  <= rate_ff;
         rsp_cmd_ff   <= cmd_ff;
         rsp_slew_ff  <= slew_ff;
      end
   end

   // output register: load when free or being taken, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_actual_angle     = rsp_angle_ff;
   assign rsp_angular_velocity = rsp_rate_ff;
   assign rsp_commanded_angle  = rsp_cmd_ff;
   assign rsp_slew_limit       = rsp_slew_ff;

   // ---------------- assertions ----------------
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_CMD))
      else $error("accepted word did not start a frame");

   a_rate_in_slew: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RATE) |=> ((rate_ff <= $signed({1'b0, slew_ff})) &&
                                (rate_ff >= -$signed({1'b0, slew_ff}))))
      else $error("rate escaped the slew limit");

   a_slew_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> ((slew_ff >= svo_pkg::SLEW_FULLLOAD) &&
                               (slew_ff <= svo_pkg::SLEW_NOLOAD)))
      else $error("slew limit out of range");

   a_sub_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ANG) |-> (sub_ff < nsub))
      else $error("substep counter overran");

   a_done_seeded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> seeded_ff)
      else $error("frame finished without seeding");

endmodule

`default_nettype wire
